// File: rtl/wpvf_pkg.sv
// Shared constants and register codes for the windowed peak/valley finder.
// No dependencies.
package wpvf_pkg;

  localparam int TIME_W       = 32;
  localparam int TRUE_W       = 32;
  localparam int CHAN_W       = 8;
  localparam int POS_W        = 16;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int DEF_MAX_SAMPLES = 65536;
  localparam int DEF_VALUE_BITS  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_TIME  = 2'd0,
    CFG_MAX_DISTANCE = 2'd1,
    CFG_EXTREME_KIND = 2'd2,
    CFG_CHANNEL_NUM  = 2'd3
  } cfg_idx_t;

endpackage

// File: rtl/windowed_peak_valley_finder.sv
// Windowed peak/valley finder top level: input register, single-pass update, result register.
// A last item's result leaves through the input register and then the result register (out_*).
// Throughput: one item per cycle; only a stalled result with a last item waiting holds the input.
// Reset (rst_n, synchronous, active low) clears registers, run state and both stages.
// Depends on wpvf_pkg and wpvf_pick.
module windowed_peak_valley_finder import wpvf_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [TIME_W-1:0]            in_sample_time,
  input  logic signed [VALUE_BITS-1:0] in_display_value,
  input  logic signed [TRUE_W-1:0]     in_true_value,
  input  logic                         in_time_ok,
  input  logic                         in_value_ok,
  input  logic                         in_last_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic                         out_from_local,
  output logic [POS_W-1:0]             out_sample_position,
  output logic [TIME_W-1:0]            out_chosen_time,
  output logic signed [VALUE_BITS-1:0] out_chosen_display,
  output logic signed [TRUE_W-1:0]     out_chosen_true,
  output logic [CHAN_W-1:0]            out_channel_echo
);

  localparam int CNT_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES - 1);
  localparam logic signed [VALUE_BITS-1:0] V_MAXPOS = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] V_MAXNEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // configuration
  logic [TIME_W-1:0] center_r, maxd_r;
  logic              kind_r;
  logic [CHAN_W-1:0] chan_r;

  // input register
  logic                         s1_valid_r, s1_valid_nxt;
  logic [TIME_W-1:0]            s1_time_r, s1_dist_r;
  logic signed [VALUE_BITS-1:0] s1_disp_r;
  logic signed [TRUE_W-1:0]     s1_true_r;
  logic                         s1_vok_r, s1_inwin_r, s1_last_r;

  // run state
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [VALUE_BITS-1:0] older_r, older_nxt;
  logic                         older_ok_r, older_ok_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic                         pend_vok_r, pend_vok_nxt;
  logic                         pend_inwin_r, pend_inwin_nxt;
  logic [TIME_W-1:0]            pend_time_r, pend_time_nxt, pend_dist_r, pend_dist_nxt;
  logic signed [VALUE_BITS-1:0] pend_disp_r, pend_disp_nxt;
  logic signed [TRUE_W-1:0]     pend_true_r, pend_true_nxt;
  logic [CNT_W-1:0]             pend_pos_r, pend_pos_nxt;
  logic                         loc_valid_r, loc_valid_nxt;
  logic [TIME_W-1:0]            loc_time_r, loc_time_nxt, loc_dist_r, loc_dist_nxt;
  logic signed [VALUE_BITS-1:0] loc_disp_r, loc_disp_nxt;
  logic signed [TRUE_W-1:0]     loc_true_r, loc_true_nxt;
  logic [CNT_W-1:0]             loc_pos_r, loc_pos_nxt;
  logic                         win_valid_r, win_valid_nxt;
  logic [TIME_W-1:0]            win_time_r, win_time_nxt, win_dist_r, win_dist_nxt;
  logic signed [VALUE_BITS-1:0] win_disp_r, win_disp_nxt;
  logic signed [TRUE_W-1:0]     win_true_r, win_true_nxt;
  logic [CNT_W-1:0]             win_pos_r, win_pos_nxt;
  logic signed [VALUE_BITS-1:0] win_low_r, win_low_nxt, win_high_r, win_high_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic                         out_local_r, out_local_nxt;
  logic [POS_W-1:0]             out_pos_r, out_pos_nxt;
  logic [TIME_W-1:0]            out_time_r, out_time_nxt;
  logic signed [VALUE_BITS-1:0] out_disp_r, out_disp_nxt;
  logic signed [TRUE_W-1:0]     out_true_r, out_true_nxt;
  logic [CHAN_W-1:0]            out_chan_r, out_chan_nxt;

  logic              adv, in_acc;
  logic [TIME_W-1:0] in_dist;
  logic              in_inwin;
  logic              judge_ok, is_max, is_min;
  logic              loc_pick_take, win_pick_take;

  assign adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    in_dist  = (in_sample_time >= center_r) ? (in_sample_time - center_r)
                                            : (center_r - in_sample_time);
    in_inwin = in_time_ok && in_value_ok && (maxd_r != '0) && (in_dist <= maxd_r);
  end

  wpvf_pick #(.VALUE_BITS(VALUE_BITS)) u_pick_local (
    .kind       (kind_r),
    .best_valid (loc_valid_r),
    .best_disp  (loc_disp_r),
    .best_dist  (loc_dist_r),
    .cand_disp  (pend_disp_r),
    .cand_dist  (pend_dist_r),
    .take       (loc_pick_take)
  );

  wpvf_pick #(.VALUE_BITS(VALUE_BITS)) u_pick_window (
    .kind       (kind_r),
    .best_valid (win_valid_r),
    .best_disp  (win_disp_r),
    .best_dist  (win_dist_r),
    .cand_disp  (s1_disp_r),
    .cand_dist  (s1_dist_r),
    .take       (win_pick_take)
  );

  always_comb begin
    judge_ok = pend_valid_r && pend_inwin_r && older_ok_r && s1_vok_r;
    is_max   = (pend_disp_r > older_r) && (pend_disp_r > s1_disp_r);
    is_min   = (pend_disp_r < older_r) && (pend_disp_r < s1_disp_r);

    s1_valid_nxt   = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    cnt_nxt        = cnt_r;
    older_nxt      = older_r;
    older_ok_nxt   = older_ok_r;
    pend_valid_nxt = pend_valid_r;
    pend_vok_nxt   = pend_vok_r;
    pend_inwin_nxt = pend_inwin_r;
    pend_time_nxt  = pend_time_r;
    pend_dist_nxt  = pend_dist_r;
    pend_disp_nxt  = pend_disp_r;
    pend_true_nxt  = pend_true_r;
    pend_pos_nxt   = pend_pos_r;
    loc_valid_nxt  = loc_valid_r;
    loc_time_nxt   = loc_time_r;
    loc_dist_nxt   = loc_dist_r;
    loc_disp_nxt   = loc_disp_r;
    loc_true_nxt   = loc_true_r;
    loc_pos_nxt    = loc_pos_r;
    win_valid_nxt  = win_valid_r;
    win_time_nxt   = win_time_r;
    win_dist_nxt   = win_dist_r;
    win_disp_nxt   = win_disp_r;
    win_true_nxt   = win_true_r;
    win_pos_nxt    = win_pos_r;
    win_low_nxt    = win_low_r;
    win_high_nxt   = win_high_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_local_nxt  = out_local_r;
    out_pos_nxt    = out_pos_r;
    out_time_nxt   = out_time_r;
    out_disp_nxt   = out_disp_r;
    out_true_nxt   = out_true_r;
    out_chan_nxt   = out_chan_r;

    if (adv) begin
      if (judge_ok && (kind_r ? is_min : is_max) && loc_pick_take) begin
        loc_valid_nxt = 1'b1;
        loc_time_nxt  = pend_time_r;
        loc_dist_nxt  = pend_dist_r;
        loc_disp_nxt  = pend_disp_r;
        loc_true_nxt  = pend_true_r;
        loc_pos_nxt   = pend_pos_r;
      end
      if (s1_inwin_r) begin
        if (s1_disp_r < win_low_r) win_low_nxt = s1_disp_r;
        if (s1_disp_r > win_high_r) win_high_nxt = s1_disp_r;
        if (win_pick_take) begin
          win_valid_nxt = 1'b1;
          win_time_nxt  = s1_time_r;
          win_dist_nxt  = s1_dist_r;
          win_disp_nxt  = s1_disp_r;
          win_true_nxt  = s1_true_r;
          win_pos_nxt   = cnt_r;
        end
      end
      older_ok_nxt   = pend_valid_r && pend_vok_r;
      older_nxt      = pend_disp_r;
      pend_valid_nxt = 1'b1;
      pend_vok_nxt   = s1_vok_r;
      pend_inwin_nxt = s1_inwin_r;
      pend_time_nxt  = s1_time_r;
      pend_dist_nxt  = s1_dist_r;
      pend_disp_nxt  = s1_disp_r;
      pend_true_nxt  = s1_true_r;
      pend_pos_nxt   = cnt_r;
      if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 1'b1;

      if (s1_last_r) begin
        out_valid_nxt = 1'b1;
        out_chan_nxt  = chan_r;
        if (loc_valid_nxt) begin
          out_found_nxt = 1'b1;
          out_local_nxt = 1'b1;
          out_pos_nxt   = POS_W'(loc_pos_nxt);
          out_time_nxt  = loc_time_nxt;
          out_disp_nxt  = loc_disp_nxt;
          out_true_nxt  = loc_true_nxt;
        end else if (win_valid_nxt && (win_high_nxt > win_low_nxt)) begin
          out_found_nxt = 1'b1;
          out_local_nxt = 1'b0;
          out_pos_nxt   = POS_W'(win_pos_nxt);
          out_time_nxt  = win_time_nxt;
          out_disp_nxt  = win_disp_nxt;
          out_true_nxt  = win_true_nxt;
        end else begin
          out_found_nxt = 1'b0;
          out_local_nxt = 1'b0;
          out_pos_nxt   = '0;
          out_time_nxt  = '0;
          out_disp_nxt  = '0;
          out_true_nxt  = '0;
        end
        // drop run state for the next run
        cnt_nxt        = '0;
        older_nxt      = '0;
        older_ok_nxt   = 1'b0;
        pend_valid_nxt = 1'b0;
        pend_vok_nxt   = 1'b0;
        pend_inwin_nxt = 1'b0;
        loc_valid_nxt  = 1'b0;
        win_valid_nxt  = 1'b0;
        win_low_nxt    = V_MAXPOS;
        win_high_nxt   = V_MAXNEG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r     <= '0;
      maxd_r       <= '0;
      kind_r       <= 1'b0;
      chan_r       <= '0;
      s1_valid_r   <= 1'b0;
      cnt_r        <= '0;
      older_r      <= '0;
      older_ok_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_vok_r   <= 1'b0;
      pend_inwin_r <= 1'b0;
      loc_valid_r  <= 1'b0;
      win_valid_r  <= 1'b0;
      win_low_r    <= V_MAXPOS;
      win_high_r   <= V_MAXNEG;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CENTER_TIME:  center_r <= cfg_wdata[TIME_W-1:0];
          CFG_MAX_DISTANCE: maxd_r   <= cfg_wdata[TIME_W-1:0];
          CFG_EXTREME_KIND: kind_r   <= cfg_wdata[0];
          CFG_CHANNEL_NUM:  chan_r   <= cfg_wdata[CHAN_W-1:0];
          default: ;
        endcase
      end
      s1_valid_r   <= s1_valid_nxt;
      cnt_r        <= cnt_nxt;
      older_r      <= older_nxt;
      older_ok_r   <= older_ok_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_vok_r   <= pend_vok_nxt;
      pend_inwin_r <= pend_inwin_nxt;
      loc_valid_r  <= loc_valid_nxt;
      win_valid_r  <= win_valid_nxt;
      win_low_r    <= win_low_nxt;
      win_high_r   <= win_high_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_time_r  <= in_sample_time;
      s1_dist_r  <= in_dist;
      s1_disp_r  <= in_display_value;
      s1_true_r  <= in_true_value;
      s1_vok_r   <= in_value_ok;
      s1_inwin_r <= in_inwin;
      s1_last_r  <= in_last_sample;
    end
    pend_time_r <= pend_time_nxt;
    pend_dist_r <= pend_dist_nxt;
    pend_disp_r <= pend_disp_nxt;
    pend_true_r <= pend_true_nxt;
    pend_pos_r  <= pend_pos_nxt;
    loc_time_r  <= loc_time_nxt;
    loc_dist_r  <= loc_dist_nxt;
    loc_disp_r  <= loc_disp_nxt;
    loc_true_r  <= loc_true_nxt;
    loc_pos_r   <= loc_pos_nxt;
    win_time_r  <= win_time_nxt;
    win_dist_r  <= win_dist_nxt;
    win_disp_r  <= win_disp_nxt;
    win_true_r  <= win_true_nxt;
    win_pos_r   <= win_pos_nxt;
    out_found_r <= out_found_nxt;
    out_local_r <= out_local_nxt;
    out_pos_r   <= out_pos_nxt;
    out_time_r  <= out_time_nxt;
    out_disp_r  <= out_disp_nxt;
    out_true_r  <= out_true_nxt;
    out_chan_r  <= out_chan_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_from_local      = out_local_r;
  assign out_sample_position = out_pos_r;
  assign out_chosen_time     = out_time_r;
  assign out_chosen_display  = out_disp_r;
  assign out_chosen_true     = out_true_r;
  assign out_channel_echo    = out_chan_r;

`ifndef SYNTHESIS
  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> (cnt_r == '0) && !pend_valid_r && !loc_valid_r && !win_valid_r)
    else $error("run state not cleared after last item");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> out_valid_r)
    else $error("last item produced no result");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (!out_local_r && (out_pos_r == '0)))
    else $error("empty result carries data");

  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    win_valid_r |-> (win_high_r >= win_low_r))
    else $error("window range inverted");
`endif

endmodule

// File: rtl/wpvf_pick.sv
// Candidate-versus-best decision: no best yet, stronger value, or equal value nearer the center.
// Depends on wpvf_pkg.
module wpvf_pick import wpvf_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         kind,
  input  logic                         best_valid,
  input  logic signed [VALUE_BITS-1:0] best_disp,
  input  logic [TIME_W-1:0]            best_dist,
  input  logic signed [VALUE_BITS-1:0] cand_disp,
  input  logic [TIME_W-1:0]            cand_dist,
  output logic                         take
);

  logic better;
  logic tie;

  always_comb begin
    better = kind ? (cand_disp < best_disp) : (cand_disp > best_disp);
    tie    = (cand_disp == best_disp) && (cand_dist < best_dist);
    take   = !best_valid || better || tie;
  end

endmodule

// File: tb/sv/windowed_peak_valley_finder_tb.sv
// Testbench for windowed_peak_valley_finder: drives sample runs through a valid/ready driver,
// predicts each run's peak or valley, and checks every result as it leaves the block.
// Depends on wpvf_pkg and the windowed_peak_valley_finder RTL.
`timescale 1ns / 1ps

module windowed_peak_valley_finder_tb;
  import wpvf_pkg::*;

  localparam int VB          = DEF_VALUE_BITS;
  localparam int POS_MAX     = DEF_MAX_SAMPLES - 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [VB-1:0]     disp;
    logic [TRUE_W-1:0] truev;
    logic              tok;
    logic              vok;
    logic              last;
  } sample_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] tstamp;
    logic [VB-1:0]     disp;
    logic [TRUE_W-1:0] truev;
    logic [POS_W-1:0]  pos;
  } pick_t;

  typedef struct packed {
    logic              found;
    logic              from_local;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] tstamp;
    logic [VB-1:0]     disp;
    logic [TRUE_W-1:0] truev;
    logic [CHAN_W-1:0] chan;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic out_from_local;
  logic [POS_W-1:0] out_sample_position;
  logic [TIME_W-1:0] out_chosen_time;
  logic [VB-1:0] out_chosen_display;
  logic signed [TRUE_W-1:0] out_chosen_true;
  logic [CHAN_W-1:0] out_channel_echo;

  sample_t drv_item = '0;
  sample_t sample_queue[$];
  outcome_t expected_extremes[$];

  logic [31:0] cfg_center = '0;
  logic [31:0] cfg_dist = '0;
  bit cfg_kind = 1'b0;
  logic [CHAN_W-1:0] cfg_chan = '0;

  int unsigned run_pos;
  logic [VB-1:0] older_disp;
  bit older_ok;
  pick_t held;
  bit held_vok;
  bit held_inwin;
  pick_t local_pick;
  pick_t window_pick;
  logic signed [VB-1:0] win_lo;
  logic signed [VB-1:0] win_hi;

  bit calm = 1'b0;
  int send_gap = 0;
  int take_gap = 0;
  int error_count = 0;
  int cycle_count;

  logic [TIME_W-1:0] in_sample_time;
  logic signed [VB-1:0] in_display_value;
  logic signed [TRUE_W-1:0] in_true_value;
  logic in_time_ok;
  logic in_value_ok;
  logic in_last_sample;

  assign in_sample_time   = drv_item.tstamp;
  assign in_display_value = drv_item.disp;
  assign in_true_value    = drv_item.truev;
  assign in_time_ok       = drv_item.tok;
  assign in_value_ok      = drv_item.vok;
  assign in_last_sample   = drv_item.last;

  windowed_peak_valley_finder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample_time      (in_sample_time),
    .in_display_value    (in_display_value),
    .in_true_value       (in_true_value),
    .in_time_ok          (in_time_ok),
    .in_value_ok         (in_value_ok),
    .in_last_sample      (in_last_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_found           (out_found),
    .out_from_local      (out_from_local),
    .out_sample_position (out_sample_position),
    .out_chosen_time     (out_chosen_time),
    .out_chosen_display  (out_chosen_display),
    .out_chosen_true     (out_chosen_true),
    .out_channel_echo    (out_channel_echo)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] center_offset(logic [31:0] t);
    return (t >= cfg_center) ? t - cfg_center : cfg_center - t;
  endfunction

  function automatic pick_t stronger_pick(pick_t best, pick_t cand);
    bit beats;
    bit tie;
    beats = cfg_kind ? ($signed(cand.disp) < $signed(best.disp))
                     : ($signed(cand.disp) > $signed(best.disp));
    tie = (cand.disp == best.disp) &&
          (center_offset(cand.tstamp) < center_offset(best.tstamp));
    return (!best.valid || beats || tie) ? cand : best;
  endfunction

  function automatic void clear_run_state();
    run_pos    = 0;
    older_disp = '0;
    older_ok   = 1'b0;
    held       = '0;
    held_vok   = 1'b0;
    held_inwin = 1'b0;
    local_pick = '0;
    window_pick = '0;
    win_lo = {1'b0, {(VB-1){1'b1}}};
    win_hi = {1'b1, {(VB-1){1'b0}}};
  endfunction

  function automatic void predict_extreme(sample_t s);
    pick_t cur;
    pick_t chosen;
    outcome_t res;
    bit inwin;
    bit is_max;
    bit is_min;
    bit have;
    bit loc;
    cur.valid  = 1'b1;
    cur.tstamp = s.tstamp;
    cur.disp   = s.disp;
    cur.truev  = s.truev;
    cur.pos    = run_pos[POS_W-1:0];
    inwin = s.tok && s.vok && (cfg_dist != 0) && (center_offset(s.tstamp) <= cfg_dist);

    // judge the held sample now that both neighbors are known
    if (held.valid && held_inwin && older_ok && s.vok) begin
      is_max = ($signed(held.disp) > $signed(older_disp)) && ($signed(held.disp) > $signed(s.disp));
      is_min = ($signed(held.disp) < $signed(older_disp)) && ($signed(held.disp) < $signed(s.disp));
      if ((!cfg_kind && is_max) || (cfg_kind && is_min))
        local_pick = stronger_pick(local_pick, held);
    end

    if (inwin) begin
      if ($signed(s.disp) < win_lo) win_lo = s.disp;
      if ($signed(s.disp) > win_hi) win_hi = s.disp;
      window_pick = stronger_pick(window_pick, cur);
    end

    older_ok   = held.valid && held_vok;
    older_disp = held.valid ? held.disp : '0;
    held       = cur;
    held_vok   = s.vok;
    held_inwin = inwin;
    if (run_pos < POS_MAX) run_pos++;

    if (s.last) begin
      have = 1'b0;
      loc = 1'b0;
      chosen = '0;
      if (local_pick.valid) begin
        chosen = local_pick;
        have = 1'b1;
        loc = 1'b1;
      end else if (window_pick.valid && (win_hi > win_lo)) begin
        chosen = window_pick;
        have = 1'b1;
      end
      res = '0;
      res.found = have;
      res.from_local = loc;
      if (have) begin
        res.pos    = chosen.pos;
        res.tstamp = chosen.tstamp;
        res.disp   = chosen.disp;
        res.truev  = chosen.truev;
      end
      res.chan = cfg_chan;
      expected_extremes.push_back(res);
      clear_run_state();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, seen);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    outcome_t want;
    if (expected_extremes.size() == 0) begin
      $display("%0t: result with none expected, found %b pos %0d",
               $time, out_found, out_sample_position);
      error_count++;
      return;
    end
    want = expected_extremes.pop_front();
    cmp_field("found", want.found, out_found);
    cmp_field("from_local", want.from_local, out_from_local);
    cmp_field("sample_position", want.pos, out_sample_position);
    cmp_field("chosen_time", want.tstamp, out_chosen_time);
    cmp_field("chosen_display", want.disp, out_chosen_display);
    cmp_field("chosen_true", want.truev, out_chosen_true);
    cmp_field("channel_echo", want.chan, out_channel_echo);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_extreme(drv_item);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          drv_item <= sample_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        take_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_CENTER_TIME:  cfg_center = data;
      CFG_MAX_DISTANCE: cfg_dist = data;
      CFG_EXTREME_KIND: cfg_kind = data[0];
      CFG_CHANNEL_NUM:  cfg_chan = data[CHAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [31:0] c, logic [31:0] d, bit k, logic [CHAN_W-1:0] ch);
    write_reg(CFG_CENTER_TIME, c);
    write_reg(CFG_MAX_DISTANCE, d);
    write_reg(CFG_EXTREME_KIND, {31'b0, k});
    write_reg(CFG_CHANNEL_NUM, {24'b0, ch});
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid || expected_extremes.size() != 0)
      @(negedge clk);
  endtask

  task automatic settle();
    wait_idle();
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_sample(logic [31:0] t, logic [VB-1:0] d, logic [31:0] tv,
                                     bit tok, bit vok, bit last);
    sample_t s;
    s.tstamp = t;
    s.disp   = d;
    s.truev  = tv;
    s.tok    = tok;
    s.vok    = vok;
    s.last   = last;
    sample_queue.push_back(s);
  endfunction

  function automatic logic [31:0] near_center();
    logic [31:0] w;
    logic [31:0] r;
    if ($urandom_range(0, 9) == 0) return $urandom;
    w = (cfg_dist > 32'h3FFF_FFFF) ? 32'h7FFF_FFFF : cfg_dist + (cfg_dist >> 2) + 1;
    r = $urandom_range(w, 0);
    return $urandom_range(0, 1) ? cfg_center + r : cfg_center - r;
  endfunction

  function automatic int add_run();
    int len;
    bit noise;
    bit wide;
    logic [31:0] t;
    logic [VB-1:0] d;
    bit tok;
    bit vok;
    noise = ($urandom_range(0, 6) == 0);
    wide  = ($urandom_range(0, 3) == 0);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      t = noise ? $urandom : near_center();
      d = wide ? VB'($urandom) : VB'($urandom_range(0, 8) - 4);
      tok = noise ? ($urandom_range(0, 1) != 0) : ($urandom_range(0, 19) != 0);
      vok = noise ? ($urandom_range(0, 1) != 0) : ($urandom_range(0, 19) != 0);
      add_sample(t, d, $urandom, tok, vok, i == len - 1);
    end
    return len;
  endfunction

  initial begin : stimulus
    logic [31:0] c;
    logic [31:0] dd;
    int added;
    clear_run_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    configure(32'd1000, 32'd100, 1'b0, 8'hA5);
    // single sample at the value extremes: flat window
    add_sample(32'd1000, 24'h7FFFFF, 32'h7FFF_FFFF, 1, 1, 1);
    // time extremes outside, window fallback on an edge sample at the boundary
    add_sample(32'd0, 24'h800000, 32'h8000_0000, 1, 1, 0);
    add_sample(32'hFFFF_FFFF, 24'h000000, 32'h0, 1, 1, 0);
    add_sample(32'd1000, 24'h800000, 32'h1234_5678, 1, 1, 0);
    add_sample(32'd1100, 24'h7FFFFF, 32'hFFFF_FFFF, 1, 1, 1);
    // neighbor without a valid time still counts
    add_sample(32'd5, 0, 32'd1, 0, 1, 0);
    add_sample(32'd1000, 50, 32'd2, 1, 1, 0);
    add_sample(32'd1002, 10, 32'd3, 1, 1, 1);
    // unusable neighbor blocks the peak
    add_sample(32'd995, 1, 32'd4, 1, 1, 0);
    add_sample(32'd1000, 100, 32'd5, 1, 1, 0);
    add_sample(32'd1005, 0, 32'd6, 1, 0, 1);
    // equal peaks: nearer the center wins
    add_sample(32'd990, 0, 32'd7, 1, 1, 0);
    add_sample(32'd980, 70, 32'd8, 1, 1, 0);
    add_sample(32'd990, 0, 32'd9, 1, 1, 0);
    add_sample(32'd999, 70, 32'd10, 1, 1, 0);
    add_sample(32'd990, 0, 32'd11, 1, 1, 1);
    // flat window
    add_sample(32'd990, 5, 32'd12, 1, 1, 0);
    add_sample(32'd1000, 5, 32'd13, 1, 1, 0);
    add_sample(32'd1010, 5, 32'd14, 1, 1, 1);
    settle();

    configure(32'd1000, 32'd100, 1'b1, 8'h00);
    add_sample(32'd1000, 20, 32'd15, 1, 1, 0);
    add_sample(32'd1001, -30, 32'd16, 1, 1, 0);
    add_sample(32'd1002, 20, 32'd17, 1, 1, 1);
    settle();

    configure(32'd1000, 32'd0, 1'b0, 8'hFF);
    add_sample(32'd1000, 1, 32'd18, 1, 1, 0);
    add_sample(32'd1000, 9, 32'd19, 1, 1, 0);
    add_sample(32'd1000, 2, 32'd20, 1, 1, 1);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      calm = (ph % 4 == 3);
      case (ph % 4)
        0: c = 32'd0;
        1: c = 32'hFFFF_FFFF;
        2: c = $urandom;
        default: c = $urandom_range(0, 3000);
      endcase
      case (ph % 5)
        0: dd = $urandom_range(1, 64);
        1: dd = 32'hFFFF_FFFF;
        2: dd = 32'd0;
        3: dd = $urandom_range(1, 5000);
        default: dd = $urandom;
      endcase
      configure(c, dd, (ph % 3 == 1),
                (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
      added = 0;
      while (added < 42) added += add_run();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
      @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
